FILE: sv/hsv_color_converter_core_macros.svh
// ----------------------------------------------------------------------------
// HSV color converter assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HSV_COLOR_CONVERTER_CORE_MACROS_SVH
`define HSV_COLOR_CONVERTER_CORE_MACROS_SVH

// cond implies prop at the same edge
`define HCC_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// cond never seen
`define HCC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: sv/hcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV color converter package
// Command codes, channel select codes and fixed field constants.
// ----------------------------------------------------------------------------
package hcc_pkg;

  typedef enum logic [1:0] {
    CMD_TO_HSV = 2'd0,
    CMD_TO_RGB = 2'd1,
    CMD_BRIGHT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MAX_R = 2'd0,
    MAX_G = 2'd1,
    MAX_B = 2'd2
  } chan_t;

  localparam int FIELD_W   = 12;
  localparam int AMT_W     = 13;
  localparam int HUE_W     = 11;
  localparam int SEXT_BITS = 8;
  localparam int SEXT      = 256;
  localparam int HUE_TURN  = 1536;
  localparam int FIELD_MAX = 4095;

endpackage

FILE: sv/hcc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV color converter pipelined divider
// Restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module hcc_div #(
  parameter int W  = 12,
  parameter int QW = 12
) (
  input  logic              clk,
  input  logic [W+QW-1:0]   num,
  input  logic [W-1:0]      den,
  output logic [QW-1:0]     quo,
  output logic [W-1:0]      rem
);
  localparam int RW = W + QW;

  logic [RW-1:0] r_st [QW+1];
  logic [W-1:0]  d_st [QW+1];
  logic [QW-1:0] q_st [QW+1];

  assign r_st[0] = num;
  assign d_st[0] = den;
  assign q_st[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = RW'(d_st[k]) << B;
    assign ge = (r_st[k] >= sh);
    always_ff @(posedge clk) begin
      r_st[k+1] <= ge ? (r_st[k] - sh) : r_st[k];
      d_st[k+1] <= d_st[k];
      q_st[k+1] <= q_st[k] | (QW'(ge) << B);
    end
  end

  assign quo = q_st[QW];
  assign rem = r_st[QW][W-1:0];

endmodule

FILE: sv/hcc_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV color converter output back end
// HSV to RGB in four stages, plus field saturation of the saturation, value and RGB results.
// ----------------------------------------------------------------------------
module hcc_rgb #(
  parameter int W = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  hcc_pkg::cmd_t               in_cmd,
  input  logic [hcc_pkg::HUE_W-1:0]   in_h,
  input  logic [W-1:0]                in_s,
  input  logic [W-1:0]                in_v,
  output logic                        out_valid,
  output logic [hcc_pkg::FIELD_W-1:0] out_first,
  output logic [hcc_pkg::FIELD_W-1:0] out_second,
  output logic [hcc_pkg::FIELD_W-1:0] out_third
);
  import hcc_pkg::*;

  localparam int PW = 2 * W;
  localparam int TW = W + 11;
  localparam int CW = (W + 2 > 13) ? W + 2 : 13;
  localparam logic [W-1:0] CMAX = {W{1'b1}};

  function automatic logic [FIELD_W-1:0] clamp_field(input logic signed [CW-1:0] x);
    logic [FIELD_W-1:0] y;
    if (x < 0) y = '0;
    else if (x > $signed(CW'(FIELD_MAX))) y = FIELD_W'(FIELD_MAX);
    else y = x[FIELD_W-1:0];
    return y;
  endfunction

  // sextant select
  logic signed [11:0] hx;
  logic signed [9:0]  t;
  chan_t              top;
  logic [PW-1:0]      prod;

  always_comb begin
    hx = $signed({1'b0, in_h});
    if (in_h < HUE_W'(SEXT)) begin
      t = 10'(hx); top = MAX_R;
    end else if (in_h >= HUE_W'(5 * SEXT)) begin
      t = 10'(hx - $signed(12'(HUE_TURN))); top = MAX_R;
    end else if (in_h < HUE_W'(3 * SEXT)) begin
      t = 10'(hx - $signed(12'(2 * SEXT))); top = MAX_G;
    end else begin
      t = 10'(hx - $signed(12'(4 * SEXT))); top = MAX_B;
    end
    prod = PW'(in_s) * PW'(in_v);
  end

  logic               f_valid;
  cmd_t               f_cmd;
  logic signed [9:0]  f_t;
  chan_t              f_top;
  logic [PW-1:0]      f_prod;
  logic [HUE_W-1:0]   f_h;
  logic [W-1:0]       f_s, f_v;

  always_ff @(posedge clk) begin
    if (rst) f_valid <= 1'b0;
    else f_valid <= in_valid;
    f_cmd  <= in_cmd;
    f_t    <= t;
    f_top  <= top;
    f_prod <= prod;
    f_h    <= in_h;
    f_s    <= in_s;
    f_v    <= in_v;
  end

  // divide by CMAX: fold high half, then up to two corrections
  logic [W-1:0] q0;
  logic [W:0]   rr, d2w;

  always_comb begin
    q0  = f_prod[PW-1:W];
    rr  = (W+1)'(f_prod[W-1:0]) + (W+1)'(q0);
    d2w = (W+1)'(q0) + (W+1)'(rr >= (W+1)'(CMAX)) + (W+1)'(rr >= {CMAX, 1'b0});
  end

  logic               g_valid;
  cmd_t               g_cmd;
  logic signed [9:0]  g_t;
  chan_t              g_top;
  logic [W-1:0]       g_d2;
  logic [HUE_W-1:0]   g_h;
  logic [W-1:0]       g_s, g_v;

  always_ff @(posedge clk) begin
    if (rst) g_valid <= 1'b0;
    else g_valid <= f_valid;
    g_cmd <= f_cmd;
    g_t   <= f_t;
    g_top <= f_top;
    g_d2  <= W'(d2w);
    g_h   <= f_h;
    g_s   <= f_s;
    g_v   <= f_v;
  end

  logic signed [TW-1:0] tp;
  assign tp = TW'(g_t) * TW'($signed({1'b0, g_d2}));

  logic                 h_valid;
  cmd_t                 h_cmd;
  chan_t                h_top;
  logic signed [TW-1:0] h_tp;
  logic [W-1:0]         h_base;
  logic [HUE_W-1:0]     h_h;
  logic [W-1:0]         h_s, h_v;

  always_ff @(posedge clk) begin
    if (rst) h_valid <= 1'b0;
    else h_valid <= g_valid;
    h_cmd  <= g_cmd;
    h_top  <= g_top;
    h_tp   <= tp;
    h_base <= g_v - g_d2;
    h_h    <= g_h;
    h_s    <= g_s;
    h_v    <= g_v;
  end

  logic signed [TW-1:0] hd;
  logic signed [CW-1:0] hdc, basec, vc, up, dn, rc, gc, bc;
  logic [FIELD_W-1:0]   o1, o2, o3;

  always_comb begin
    hd    = h_tp >>> SEXT_BITS;
    hdc   = CW'(hd);
    basec = $signed(CW'(h_base));
    vc    = $signed(CW'(h_v));
    if (hd <= 0) begin
      up = basec;
      dn = basec - hdc;
    end else begin
      dn = basec;
      up = basec + hdc;
    end
    case (h_top)
      MAX_R: begin rc = vc; gc = up; bc = dn; end
      MAX_G: begin gc = vc; bc = up; rc = dn; end
      default: begin bc = vc; rc = up; gc = dn; end
    endcase
    case (h_cmd)
      CMD_TO_HSV: begin
        o1 = FIELD_W'(h_h);
        o2 = clamp_field($signed(CW'(h_s)));
        o3 = clamp_field(vc);
      end
      CMD_TO_RGB, CMD_BRIGHT: begin
        o1 = clamp_field(rc);
        o2 = clamp_field(gc);
        o3 = clamp_field(bc);
      end
      default: begin
        o1 = '0; o2 = '0; o3 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= h_valid;
    out_first  <= o1;
    out_second <= o2;
    out_third  <= o3;
  end

endmodule

FILE: sv/hsv_color_converter_core.sv
`timescale 1ns / 1ps
// Start passes capture, stage 2, the divider stages, the e register and the back end to done.
// Throughput: one transaction per cycle; busy is always low.
// The hue and saturation dividers are bit-per-stage.
// Reset (rst, synchronous) clears all valid bits; transactions in flight are dropped.
// ----------------------------------------------------------------------------
// HSV color converter core
// RGB to HSV, HSV to RGB and brightness adjust in a fully pipelined datapath.
// ----------------------------------------------------------------------------
module hsv_color_converter_core #(
  parameter int CHANNEL_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         cmd,
  input  logic [hcc_pkg::FIELD_W-1:0]        first_in,
  input  logic [hcc_pkg::FIELD_W-1:0]        second_in,
  input  logic [hcc_pkg::FIELD_W-1:0]        third_in,
  input  logic signed [hcc_pkg::AMT_W-1:0]   amount,
  output logic                               done,
  output logic [hcc_pkg::FIELD_W-1:0]        first_out,
  output logic [hcc_pkg::FIELD_W-1:0]        second_out,
  output logic [hcc_pkg::FIELD_W-1:0]        third_out
);
  import hcc_pkg::*;

  localparam int W  = CHANNEL_BITS;
  localparam int QW = (W > 9) ? W : 9;
  localparam int RW = W + QW;
  localparam int VW = (W > 12) ? W + 2 : 15;
  localparam logic [W-1:0] CMAX = {W{1'b1}};

  assign busy = 1'b0;

  // stage 1: capture
  logic                    s1_valid;
  cmd_t                    s1_cmd;
  logic [W-1:0]            s1_r, s1_g, s1_b;
  logic [FIELD_W-1:0]      s1_h;
  logic signed [AMT_W-1:0] s1_amt;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= start;
    s1_cmd <= cmd_t'(cmd);
    s1_r   <= W'(first_in);
    s1_g   <= W'(second_in);
    s1_b   <= W'(third_in);
    s1_h   <= first_in;
    s1_amt <= amount;
  end

  // stage 2: max/min, hue and saturation numerators
  logic [W-1:0]       mx, mn, dlt, mag;
  chan_t              sel;
  logic signed [W:0]  diff;
  logic               neg;
  logic [FIELD_W-1:0] hm;

  always_comb begin
    mx = s1_r; sel = MAX_R;
    if (s1_g > mx) begin mx = s1_g; sel = MAX_G; end
    if (s1_b > mx) begin mx = s1_b; sel = MAX_B; end
    mn = s1_r;
    if (s1_g < mn) mn = s1_g;
    if (s1_b < mn) mn = s1_b;
    dlt = mx - mn;
    case (sel)
      MAX_R: diff = $signed({1'b0, s1_g}) - $signed({1'b0, s1_b});
      MAX_G: diff = $signed({1'b0, s1_b}) - $signed({1'b0, s1_r});
      default: diff = $signed({1'b0, s1_r}) - $signed({1'b0, s1_g});
    endcase
    neg = diff[W];
    mag = neg ? W'(-diff) : W'(diff);
    if (s1_h >= FIELD_W'(2 * HUE_TURN)) hm = s1_h - FIELD_W'(2 * HUE_TURN);
    else if (s1_h >= FIELD_W'(HUE_TURN)) hm = s1_h - FIELD_W'(HUE_TURN);
    else hm = s1_h;
  end

  logic                    s2_valid;
  cmd_t                    s2_cmd;
  logic [W-1:0]            s2_mx, s2_dlt, s2_s, s2_v;
  logic                    s2_dz, s2_neg;
  chan_t                   s2_sel;
  logic [HUE_W-1:0]        s2_hm;
  logic signed [AMT_W-1:0] s2_amt;
  logic [RW-1:0]           s2_hnum, s2_snum;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else s2_valid <= s1_valid;
    s2_cmd  <= s1_cmd;
    s2_mx   <= mx;
    s2_dlt  <= dlt;
    s2_dz   <= (dlt == '0);
    s2_neg  <= neg;
    s2_sel  <= sel;
    s2_hm   <= HUE_W'(hm);
    s2_s    <= s1_g;
    s2_v    <= s1_b;
    s2_amt  <= s1_amt;
    s2_hnum <= RW'(mag) << SEXT_BITS;
    s2_snum <= (RW'(dlt) << W) - RW'(dlt);
  end

  // dividers
  logic [QW-1:0] hq, sq;
  logic [W-1:0]  hr, sr_unused_rem;

  hcc_div #(.W(W), .QW(QW)) u_hdiv (
    .clk (clk),
    .num (s2_hnum),
    .den (s2_dlt),
    .quo (hq),
    .rem (hr)
  );

  hcc_div #(.W(W), .QW(QW)) u_sdiv (
    .clk (clk),
    .num (s2_snum),
    .den (s2_mx),
    .quo (sq),
    .rem (sr_unused_rem)
  );

  // sideband alongside the dividers
  logic [QW-1:0]           dl_valid;
  cmd_t                    dl_cmd [QW];
  logic [W-1:0]            dl_mx  [QW];
  logic [W-1:0]            dl_s   [QW];
  logic [W-1:0]            dl_v   [QW];
  logic                    dl_dz  [QW];
  logic                    dl_neg [QW];
  chan_t                   dl_sel [QW];
  logic [HUE_W-1:0]        dl_hm  [QW];
  logic signed [AMT_W-1:0] dl_amt [QW];

  always_ff @(posedge clk) begin
    if (rst) dl_valid <= '0;
    else dl_valid <= {dl_valid[QW-2:0], s2_valid};
    dl_cmd[0] <= s2_cmd;
    dl_mx[0]  <= s2_mx;
    dl_s[0]   <= s2_s;
    dl_v[0]   <= s2_v;
    dl_dz[0]  <= s2_dz;
    dl_neg[0] <= s2_neg;
    dl_sel[0] <= s2_sel;
    dl_hm[0]  <= s2_hm;
    dl_amt[0] <= s2_amt;
    for (int k = 1; k < QW; k++) begin
      dl_cmd[k] <= dl_cmd[k-1];
      dl_mx[k]  <= dl_mx[k-1];
      dl_s[k]   <= dl_s[k-1];
      dl_v[k]   <= dl_v[k-1];
      dl_dz[k]  <= dl_dz[k-1];
      dl_neg[k] <= dl_neg[k-1];
      dl_sel[k] <= dl_sel[k-1];
      dl_hm[k]  <= dl_hm[k-1];
      dl_amt[k] <= dl_amt[k-1];
    end
  end

  // hue fixup, value adjust, operand select
  logic [HUE_W-1:0]     off, hv, eh;
  logic [11:0]          hu;
  logic [W-1:0]         sat, vb, es, ev;
  logic signed [VW-1:0] vsum;

  always_comb begin
    case (dl_sel[QW-1])
      MAX_R: off = '0;
      MAX_G: off = HUE_W'(2 * SEXT);
      default: off = HUE_W'(4 * SEXT);
    endcase
    if (dl_neg[QW-1]) hu = 12'(off) - 12'(hq) - 12'(hr != '0);
    else hu = 12'(off) + 12'(hq);
    if (hu[11]) hu = hu + 12'(HUE_TURN);
    hv  = dl_dz[QW-1] ? '0 : HUE_W'(hu);
    sat = dl_dz[QW-1] ? '0 : W'(sq);
    vsum = $signed(VW'(dl_mx[QW-1])) + VW'(dl_amt[QW-1]);
    if (vsum < 0) vb = '0;
    else if (vsum > $signed(VW'(CMAX))) vb = CMAX;
    else vb = W'(vsum);
    case (dl_cmd[QW-1])
      CMD_TO_HSV: begin eh = hv; es = sat; ev = dl_mx[QW-1]; end
      CMD_TO_RGB: begin eh = dl_hm[QW-1]; es = dl_s[QW-1]; ev = dl_v[QW-1]; end
      CMD_BRIGHT: begin eh = hv; es = sat; ev = vb; end
      default: begin eh = '0; es = '0; ev = '0; end
    endcase
  end

  logic             e_valid;
  cmd_t             e_cmd;
  logic [HUE_W-1:0] e_h;
  logic [W-1:0]     e_s, e_v;

  always_ff @(posedge clk) begin
    if (rst) e_valid <= 1'b0;
    else e_valid <= dl_valid[QW-1];
    e_cmd <= dl_cmd[QW-1];
    e_h   <= eh;
    e_s   <= es;
    e_v   <= ev;
  end

  hcc_rgb #(.W(W)) u_rgb (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (e_valid),
    .in_cmd     (e_cmd),
    .in_h       (e_h),
    .in_s       (e_s),
    .in_v       (e_v),
    .out_valid  (done),
    .out_first  (first_out),
    .out_second (second_out),
    .out_third  (third_out)
  );

endmodule

FILE: sv/hcc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV color converter port checker
// Busy, latency, command and range checks seen at the core's ports.
// ----------------------------------------------------------------------------
`include "hsv_color_converter_core_macros.svh"

module hcc_port_checker #(
  parameter int CHANNEL_BITS = 12
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic [1:0]                  cmd,
  input logic                        done,
  input logic [hcc_pkg::FIELD_W-1:0] first_out,
  input logic [hcc_pkg::FIELD_W-1:0] second_out,
  input logic [hcc_pkg::FIELD_W-1:0] third_out
);
  import hcc_pkg::*;

  localparam int QW    = (CHANNEL_BITS > 9) ? CHANNEL_BITS : 9;
  localparam int LAT   = QW + 7;
  localparam int CNT_W = $clog2(LAT + 1);

  logic [CNT_W-1:0] cnt;
  logic             warm;
  logic             acc;
  logic             is_none;
  logic             is_hsv;
  logic             out_zero;
  logic             hue_ok;

  assign warm     = (cnt == CNT_W'(LAT));
  assign acc      = start && !busy;
  assign is_none  = (cmd == CMD_NONE);
  assign is_hsv   = (cmd == CMD_TO_HSV);
  assign out_zero = (first_out == '0) && (second_out == '0) && (third_out == '0);
  assign hue_ok   = (first_out < FIELD_W'(HUE_TURN));

  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else if (!warm) cnt <= cnt + CNT_W'(1);
  end

  `HCC_ASSERT_NEVER(a_busy_low, busy, "busy raised")
  `HCC_ASSERT_IMPL(a_latency, warm, done == $past(acc, LAT), "done latency")
  `HCC_ASSERT_IMPL(a_none_zero, warm && done && $past(is_none, LAT), out_zero, "cmd 3 output")
  `HCC_ASSERT_IMPL(a_hue_range, warm && done && $past(is_hsv, LAT), hue_ok, "hue out of range")

endmodule

bind hsv_color_converter_core hcc_port_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_hcc_checker (.*);
